// ===== hw/rtl/hdmp_pkg.sv =====
// Shared types, codes and syntax tables of the HDR dynamic metadata parser.
package hdmp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_WINDOWS     = 2'd0;
  localparam logic [1:0] CFG_MAX_PERCENTILES = 2'd1;
  localparam logic [1:0] CFG_MAX_ANCHORS     = 2'd2;

  // Message phases
  localparam logic [1:0] PH_PARSE = 2'd0;
  localparam logic [1:0] PH_DONE  = 2'd1;
  localparam logic [1:0] PH_ERROR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_FIELD = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  // Syntax elements that steer the parse
  localparam logic [5:0] EL_VERSION      = 6'd0;
  localparam logic [5:0] EL_NUM_WINDOWS  = 6'd1;
  localparam logic [5:0] EL_GEOM_FIRST   = 6'd2;
  localparam logic [5:0] EL_OVERLAP      = 6'd12;
  localparam logic [5:0] EL_TGT_FLAG     = 6'd14;
  localparam logic [5:0] EL_TGT_ROWS     = 6'd15;
  localparam logic [5:0] EL_TGT_COLS     = 6'd16;
  localparam logic [5:0] EL_TGT_CELL     = 6'd17;
  localparam logic [5:0] EL_MAXSCL       = 6'd18;
  localparam logic [5:0] EL_AVG_MAXRGB   = 6'd19;
  localparam logic [5:0] EL_NUM_PCT      = 6'd20;
  localparam logic [5:0] EL_PERCENTAGE   = 6'd21;
  localparam logic [5:0] EL_PERCENTILE   = 6'd22;
  localparam logic [5:0] EL_FRACTION     = 6'd23;
  localparam logic [5:0] EL_MST_FLAG     = 6'd24;
  localparam logic [5:0] EL_MST_ROWS     = 6'd25;
  localparam logic [5:0] EL_MST_COLS     = 6'd26;
  localparam logic [5:0] EL_MST_CELL     = 6'd27;
  localparam logic [5:0] EL_TONE_FLAG    = 6'd28;
  localparam logic [5:0] EL_KNEE_X       = 6'd29;
  localparam logic [5:0] EL_NUM_ANCHORS  = 6'd31;
  localparam logic [5:0] EL_ANCHOR       = 6'd32;
  localparam logic [5:0] EL_SAT_FLAG     = 6'd33;
  localparam logic [5:0] EL_SAT_WEIGHT   = 6'd34;
  localparam logic [5:0] EL_COMPLETE     = 6'd35;
  localparam logic [5:0] EL_COUNT        = 6'd35;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [5:0]  element_id;
    logic [1:0]  window_index;
    logic [9:0]  element_index;
    logic [26:0] field_value;
    logic [1:0]  status;
    logic        run_last;
  } out_t;

  typedef struct packed {
    logic [1:0] max_windows;
    logic [3:0] max_percentiles;
    logic [3:0] max_anchors;
  } cfg_t;

  // Bit width of each syntax element
  function automatic logic [4:0] elem_width(input logic [5:0] p);
    logic [4:0] w;
    case (p)
      6'd0: w = 5'd8;   6'd1: w = 5'd2;   6'd2: w = 5'd16;  6'd3: w = 5'd16;
      6'd4: w = 5'd16;  6'd5: w = 5'd16;  6'd6: w = 5'd16;  6'd7: w = 5'd16;
      6'd8: w = 5'd8;   6'd9: w = 5'd16;  6'd10: w = 5'd16; 6'd11: w = 5'd16;
      6'd12: w = 5'd1;  6'd13: w = 5'd27; 6'd14: w = 5'd1;  6'd15: w = 5'd5;
      6'd16: w = 5'd5;  6'd17: w = 5'd4;  6'd18: w = 5'd17; 6'd19: w = 5'd17;
      6'd20: w = 5'd4;  6'd21: w = 5'd7;  6'd22: w = 5'd17; 6'd23: w = 5'd10;
      6'd24: w = 5'd1;  6'd25: w = 5'd5;  6'd26: w = 5'd5;  6'd27: w = 5'd4;
      6'd28: w = 5'd1;  6'd29: w = 5'd12; 6'd30: w = 5'd12; 6'd31: w = 5'd4;
      6'd32: w = 5'd10; 6'd33: w = 5'd1;  6'd34: w = 5'd6;
      default: w = 5'd8;
    endcase
    return w;
  endfunction

  // Elements that carry a window number
  function automatic logic has_window(input logic [5:0] p);
    return (p >= 6'd2 && p <= 6'd12) || (p >= 6'd18 && p <= 6'd23) ||
           (p >= 6'd28 && p <= 6'd34);
  endfunction

  // Elements that carry an element index
  function automatic logic has_index(input logic [5:0] p);
    return p == EL_TGT_CELL || p == EL_MAXSCL || p == EL_PERCENTAGE ||
           p == EL_PERCENTILE || p == EL_MST_CELL || p == EL_ANCHOR;
  endfunction

endpackage

// ===== hw/rtl/hdmp_front.sv =====
// Input byte queue: accepts message beats and hands them to the bit parser.
module hdmp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hdmp_pkg::in_t in_data_i,
  output logic          q_valid_o,
  output hdmp_pkg::in_t q_data_o,
  input  logic          q_pop_i
);
  import hdmp_pkg::*;

  in_t        mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign pop        = q_pop_i && q_valid_o;
  assign q_data_o   = mem_q[rd_ptr_q];

  // Store incoming beats
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== hw/rtl/hdmp_back.sv =====
// Bit parser: walks the syntax one bit per cycle unless stalled; emits tagged field beats.
module hdmp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hdmp_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  hdmp_pkg::in_t  q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hdmp_pkg::out_t out_data_o
);
  import hdmp_pkg::*;

  // Current byte
  logic        byte_v_q, byte_v_d;
  in_t         byte_q, byte_d;
  logic [3:0]  bpos_q, bpos_d;
  logic        done_pend_q, done_pend_d;
  logic        tail_q, tail_d;
  // Parser state
  logic [26:0] acc_q, acc_d;
  logic [4:0]  taken_q, taken_d;
  logic [5:0]  pos_q, pos_d;
  logic [1:0]  wtot_q, wtot_d;
  logic [1:0]  wcnt_q, wcnt_d;
  logic [4:0]  rows_q, rows_d;
  logic [9:0]  ecnt_q, ecnt_d;
  logic [9:0]  etot_q, etot_d;
  logic [1:0]  phase_q, phase_d;
  // Result staging and output
  logic        stage_v_q, stage_v_d;
  out_t        stage_q, stage_d;
  logic        out_v_q, out_v_d;
  out_t        out_q, out_d;

  logic        out_free, can_prod, prod, restart, load;
  out_t        res;
  logic [5:0]  p;
  logic [26:0] acc_nx, v;
  logic [4:0]  taken_nx;
  logic        bit_in, over;
  logic [1:0]  wcnt_inc;
  logic [9:0]  ecnt_inc, cells;
  logic [1:0]  cur_win;
  logic [9:0]  cur_idx;

  assign out_free    = !out_v_q || out_ready_i;
  assign can_prod    = !stage_v_q || out_free;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign p        = (pos_q < EL_COUNT) ? pos_q : EL_VERSION;
  assign bit_in   = byte_q.data_byte[3'd7 - bpos_q[2:0]];
  assign acc_nx   = {acc_q[25:0], bit_in};
  assign taken_nx = taken_q + 5'd1;
  assign wcnt_inc = wcnt_q + 2'd1;
  assign ecnt_inc = ecnt_q + 10'd1;
  assign cur_win  = has_window(p) ? wcnt_q : 2'd0;
  assign cur_idx  = has_index(p) ? ecnt_q : 10'd0;

  always_comb begin
    byte_v_d = byte_v_q;  byte_d = byte_q;  bpos_d = bpos_q;
    done_pend_d = done_pend_q;  tail_d = tail_q;
    acc_d = acc_q;  taken_d = taken_q;  pos_d = pos_q;  wtot_d = wtot_q;
    wcnt_d = wcnt_q;  rows_d = rows_q;  ecnt_d = ecnt_q;  etot_d = etot_q;
    phase_d = phase_q;
    stage_v_d = stage_v_q;  stage_d = stage_q;
    out_v_d = out_v_q && !out_ready_i;  out_d = out_q;
    prod = 1'b0;  restart = 1'b0;  load = 1'b0;  q_pop_o = 1'b0;
    res = '0;  over = 1'b0;  cells = '0;
    v = acc_nx;
    if (p == EL_NUM_WINDOWS && acc_nx == 27'd0) v = 27'd1;

    if (!byte_v_q) begin
      // Fetch next byte
      load = q_valid_i;
    end else if (done_pend_q) begin
      // Emit message complete
      if (can_prod) begin
        res = '{EL_COMPLETE, 2'd0, 10'd0, 27'd0, ST_DONE, 1'b0};
        prod = 1'b1;
        done_pend_d = 1'b0;
      end
    end else if (phase_q == PH_PARSE && bpos_q != 4'd8) begin
      // Shift in one bit
      if (taken_nx < elem_width(p)) begin
        acc_d = acc_nx;  taken_d = taken_nx;  bpos_d = bpos_q + 4'd1;
      end else if (can_prod) begin
        acc_d = '0;  taken_d = '0;  bpos_d = bpos_q + 4'd1;  prod = 1'b1;
        over = (p == EL_NUM_WINDOWS && v > {25'd0, cfg_i.max_windows}) ||
               (p == EL_NUM_PCT && v > {23'd0, cfg_i.max_percentiles}) ||
               (p == EL_NUM_ANCHORS && v > {23'd0, cfg_i.max_anchors});
        res = '{p, cur_win, cur_idx, v, over ? ST_LIMIT : ST_FIELD, 1'b0};
        if (over) begin
          phase_d = PH_ERROR;
        end else begin
          case (p)
            EL_NUM_WINDOWS: begin
              wtot_d = v[1:0];
              if (v > 27'd1) begin
                wcnt_d = 2'd1;  pos_d = EL_GEOM_FIRST;
              end else begin
                pos_d = 6'd13;
              end
            end
            EL_OVERLAP: begin
              wcnt_d = wcnt_inc;
              pos_d  = (wcnt_inc < wtot_q) ? EL_GEOM_FIRST : 6'd13;
            end
            EL_TGT_FLAG: begin
              if (v[0]) pos_d = EL_TGT_ROWS;
              else begin wcnt_d = '0; ecnt_d = '0; pos_d = EL_MAXSCL; end
            end
            EL_TGT_ROWS, EL_MST_ROWS: begin
              rows_d = v[4:0];  pos_d = p + 6'd1;
            end
            EL_TGT_COLS, EL_MST_COLS: begin
              cells  = {5'd0, rows_q} * {5'd0, v[4:0]};
              etot_d = cells;  ecnt_d = '0;
              if (cells != 10'd0) pos_d = p + 6'd1;
              else begin
                wcnt_d = '0;
                pos_d  = (p == EL_TGT_COLS) ? EL_MAXSCL : EL_TONE_FLAG;
              end
            end
            EL_TGT_CELL, EL_MST_CELL: begin
              ecnt_d = ecnt_inc;
              if (ecnt_inc >= etot_q) begin
                wcnt_d = '0;  ecnt_d = '0;
                pos_d  = (p == EL_TGT_CELL) ? EL_MAXSCL : EL_TONE_FLAG;
              end
            end
            EL_MAXSCL: begin
              ecnt_d = ecnt_inc;
              if (ecnt_inc >= 10'd3) pos_d = EL_AVG_MAXRGB;
            end
            EL_NUM_PCT, EL_NUM_ANCHORS: begin
              etot_d = {6'd0, v[3:0]};  ecnt_d = '0;
              if (v != 27'd0) pos_d = p + 6'd1;
              else pos_d = (p == EL_NUM_PCT) ? EL_FRACTION : EL_SAT_FLAG;
            end
            EL_PERCENTILE: begin
              ecnt_d = ecnt_inc;
              pos_d  = (ecnt_inc < etot_q) ? EL_PERCENTAGE : EL_FRACTION;
            end
            EL_FRACTION: begin
              wcnt_d = wcnt_inc;  ecnt_d = '0;
              pos_d  = (wcnt_inc < wtot_q) ? EL_MAXSCL : EL_MST_FLAG;
            end
            EL_MST_FLAG: begin
              if (v[0]) pos_d = EL_MST_ROWS;
              else begin wcnt_d = '0; ecnt_d = '0; pos_d = EL_TONE_FLAG; end
            end
            EL_TONE_FLAG: pos_d = v[0] ? EL_KNEE_X : EL_SAT_FLAG;
            EL_ANCHOR: begin
              ecnt_d = ecnt_inc;
              if (ecnt_inc >= etot_q) pos_d = EL_SAT_FLAG;
            end
            EL_SAT_FLAG, EL_SAT_WEIGHT: begin
              if (p == EL_SAT_FLAG && v[0]) pos_d = EL_SAT_WEIGHT;
              else begin
                wcnt_d = wcnt_inc;
                if (wcnt_inc < wtot_q) begin
                  ecnt_d = '0;  pos_d = EL_TONE_FLAG;
                end else begin
                  phase_d = PH_DONE;  done_pend_d = 1'b1;
                end
              end
            end
            default: pos_d = (p < EL_COUNT - 6'd1) ? p + 6'd1 : EL_VERSION;
          endcase
        end
      end
    end else if (byte_q.end_of_message && phase_q == PH_PARSE && !tail_q) begin
      // Report a message cut short
      if (can_prod) begin
        res = '{p, cur_win, cur_idx, 27'd0, ST_TRUNC, 1'b0};
        prod = 1'b1;  tail_d = 1'b1;
      end
    end else if (can_prod) begin
      // Flush the last result of this byte and release it
      if (stage_v_q) begin
        out_v_d = 1'b1;  out_d = stage_q;  out_d.run_last = 1'b1;
        stage_v_d = 1'b0;
      end
      restart  = byte_q.end_of_message;
      byte_v_d = 1'b0;
      load     = q_valid_i;
    end

    // Move the staged result out, stage the new one
    if (prod) begin
      if (stage_v_q) begin
        out_v_d = 1'b1;  out_d = stage_q;
      end
      stage_v_d = 1'b1;  stage_d = res;
    end

    if (restart) begin
      acc_d = '0;  taken_d = '0;  pos_d = EL_VERSION;  wtot_d = 2'd1;
      wcnt_d = '0;  rows_d = '0;  ecnt_d = '0;  etot_d = '0;  phase_d = PH_PARSE;
    end

    if (load) begin
      q_pop_o = 1'b1;  byte_v_d = 1'b1;  byte_d = q_data_i;
      bpos_d = '0;  tail_d = 1'b0;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    stage_q <= stage_d;
    out_q   <= out_d;
  end

  // Hold control and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_v_q <= 1'b0;  bpos_q <= '0;  done_pend_q <= 1'b0;  tail_q <= 1'b0;
      acc_q <= '0;  taken_q <= '0;  pos_q <= EL_VERSION;  wtot_q <= 2'd1;
      wcnt_q <= '0;  rows_q <= '0;  ecnt_q <= '0;  etot_q <= '0;  phase_q <= PH_PARSE;
      stage_v_q <= 1'b0;  out_v_q <= 1'b0;
    end else begin
      byte_v_q <= byte_v_d;  bpos_q <= bpos_d;  done_pend_q <= done_pend_d;
      tail_q <= tail_d;  acc_q <= acc_d;  taken_q <= taken_d;  pos_q <= pos_d;
      wtot_q <= wtot_d;  wcnt_q <= wcnt_d;  rows_q <= rows_d;  ecnt_q <= ecnt_d;
      etot_q <= etot_d;  phase_q <= phase_d;  stage_v_q <= stage_v_d;
      out_v_q <= out_v_d;
    end
  end
endmodule

// ===== hw/rtl/hdmp_dynamic_metadata_parser_top.sv =====
// Top level of the HDR dynamic metadata parser: config registers, queue, parser.
// Results: each result is staged and moves to the output when the next one is staged;
//   the last result of a byte, or a message complete or truncated beat, when the byte is released.
// Byte flow: the parser shifts in the bits of a byte in turn, then releases it; a byte
//   after completion or an error is released unparsed; a stalled output holds the parser.
// Reset: rst_ni clears queue and parse state; the limits return to 3, 15 and 15.
module hdr_dynamic_metadata_parser_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [3:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hdmp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hdmp_pkg::out_t out_data_o
);
  import hdmp_pkg::*;

  cfg_t cfg_q;
  logic q_valid, q_pop;
  in_t  q_data;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{2'd3, 4'd15, 4'd15};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_WINDOWS:     cfg_q.max_windows     <= cfg_data_i[1:0];
        CFG_MAX_PERCENTILES: cfg_q.max_percentiles <= cfg_data_i;
        CFG_MAX_ANCHORS:     cfg_q.max_anchors     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hdmp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  hdmp_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule

// ===== sim/hdr_dynamic_metadata_parser_top_tb.sv =====
// Testbench for the HDR dynamic metadata parser top level.
`timescale 1ns / 100ps

module hdr_dynamic_metadata_parser_top_tb;
  import hdmp_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [3:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  in_t        in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_t       out_data_o;

  hdr_dynamic_metadata_parser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  localparam int NUM_ELEMS = 35;
  localparam int FLD_W [NUM_ELEMS] = '{
    8, 2, 16, 16, 16, 16, 16, 16, 8, 16, 16, 16, 1,
    27, 1, 5, 5, 4,
    17, 17, 4, 7, 17, 10,
    1, 5, 5, 4,
    1, 12, 12, 4, 10, 1, 6
  };

  // Shadow of the block's registers and parse state
  logic [1:0]  lim_windows;
  logic [3:0]  lim_pct;
  logic [3:0]  lim_anchors;
  logic [26:0] shift_acc;
  logic [4:0]  nbits;
  logic [5:0]  cur_elem;
  logic [1:0]  win_total;
  logic [1:0]  win_cnt;
  logic [4:0]  rows;
  logic [9:0]  elem_cnt;
  logic [9:0]  elem_total;
  logic [1:0]  phase;

  out_t field_q[$];
  int   mismatches;
  int   sent_beats;
  bit   rx_stalls;
  int   rx_hold;
  bit   bitbuf[$];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Safety limit
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void restart_parse();
    shift_acc = '0; nbits = '0; cur_elem = EL_VERSION;
    win_total = 2'd1; win_cnt = '0; rows = '0;
    elem_cnt = '0; elem_total = '0; phase = PH_PARSE;
  endfunction

  function automatic logic [1:0] win_of(logic [5:0] p);
    if ((p >= 2 && p <= 12) || (p >= 18 && p <= 23) || (p >= 28 && p <= 34))
      return win_cnt;
    return 2'd0;
  endfunction

  function automatic logic [9:0] idx_of(logic [5:0] p);
    if (p == EL_TGT_CELL || p == EL_MAXSCL || p == EL_PERCENTAGE ||
        p == EL_PERCENTILE || p == EL_MST_CELL || p == EL_ANCHOR)
      return elem_cnt;
    return 10'd0;
  endfunction

  function automatic void push_field(logic [5:0] id, logic [1:0] w, logic [9:0] ix,
                                     logic [26:0] v, logic [1:0] st);
    out_t r;
    r.element_id = id; r.window_index = w; r.element_index = ix;
    r.field_value = v; r.status = st; r.run_last = 1'b0;
    field_q.push_back(r);
  endfunction

  function automatic void enter_stats();
    win_cnt = '0; elem_cnt = '0; cur_elem = EL_MAXSCL;
  endfunction

  function automatic void enter_tone();
    win_cnt = '0; elem_cnt = '0; cur_elem = EL_TONE_FLAG;
  endfunction

  function automatic void next_tone_win();
    win_cnt = win_cnt + 2'd1;
    if (win_cnt < win_total) begin
      elem_cnt = '0; cur_elem = EL_TONE_FLAG;
    end else begin
      phase = PH_DONE;
    end
  endfunction

  function automatic void grid_step(logic [5:0] p, logic [26:0] v, logic [5:0] base,
                                    bit mastering);
    if (p == base) begin
      rows = v[4:0]; cur_elem = base + 6'd1;
      return;
    end
    elem_total = 10'(rows) * 10'(v[4:0]);
    elem_cnt = '0;
    if (elem_total > 0) cur_elem = base + 6'd2;
    else if (mastering) enter_tone();
    else enter_stats();
  endfunction

  // Move to the next syntax element after field p with value v
  function automatic void step_syntax(logic [5:0] p, logic [26:0] v);
    case (p)
      EL_NUM_WINDOWS: begin
        win_total = v[1:0];
        if (v > 1) begin win_cnt = 2'd1; cur_elem = EL_GEOM_FIRST; end
        else cur_elem = 6'd13;
      end
      EL_OVERLAP: begin
        win_cnt = win_cnt + 2'd1;
        cur_elem = (win_cnt < win_total) ? EL_GEOM_FIRST : 6'd13;
      end
      EL_TGT_FLAG: begin
        if (v != 0) cur_elem = EL_TGT_ROWS; else enter_stats();
      end
      EL_TGT_ROWS, EL_TGT_COLS: grid_step(p, v, EL_TGT_ROWS, 1'b0);
      EL_TGT_CELL: begin
        elem_cnt = elem_cnt + 10'd1;
        if (elem_cnt >= elem_total) enter_stats();
      end
      EL_MAXSCL: begin
        elem_cnt = elem_cnt + 10'd1;
        if (elem_cnt >= 3) cur_elem = EL_AVG_MAXRGB;
      end
      EL_NUM_PCT: begin
        elem_total = 10'(v); elem_cnt = '0;
        cur_elem = (v > 0) ? EL_PERCENTAGE : EL_FRACTION;
      end
      EL_PERCENTILE: begin
        elem_cnt = elem_cnt + 10'd1;
        cur_elem = (elem_cnt < elem_total) ? EL_PERCENTAGE : EL_FRACTION;
      end
      EL_FRACTION: begin
        win_cnt = win_cnt + 2'd1;
        elem_cnt = '0;
        cur_elem = (win_cnt < win_total) ? EL_MAXSCL : EL_MST_FLAG;
      end
      EL_MST_FLAG: begin
        if (v != 0) cur_elem = EL_MST_ROWS; else enter_tone();
      end
      EL_MST_ROWS, EL_MST_COLS: grid_step(p, v, EL_MST_ROWS, 1'b1);
      EL_MST_CELL: begin
        elem_cnt = elem_cnt + 10'd1;
        if (elem_cnt >= elem_total) enter_tone();
      end
      EL_TONE_FLAG: cur_elem = (v != 0) ? EL_KNEE_X : EL_SAT_FLAG;
      EL_NUM_ANCHORS: begin
        elem_total = 10'(v); elem_cnt = '0;
        cur_elem = (v > 0) ? EL_ANCHOR : EL_SAT_FLAG;
      end
      EL_ANCHOR: begin
        elem_cnt = elem_cnt + 10'd1;
        if (elem_cnt >= elem_total) cur_elem = EL_SAT_FLAG;
      end
      EL_SAT_FLAG: begin
        if (v != 0) cur_elem = EL_SAT_WEIGHT; else next_tone_win();
      end
      EL_SAT_WEIGHT: next_tone_win();
      default: cur_elem = (p < NUM_ELEMS - 1) ? p + 6'd1 : 6'd0;
    endcase
  endfunction

  // Expected fields produced by one accepted byte
  function automatic void predict_fields(logic [7:0] data, logic eom);
    int start;
    logic [5:0] p;
    logic [26:0] v;
    start = field_q.size();
    for (int b = 7; b >= 0 && phase == PH_PARSE; b--) begin
      p = (cur_elem < NUM_ELEMS) ? cur_elem : 6'd0;
      shift_acc = {shift_acc[25:0], data[b]};
      nbits = nbits + 5'd1;
      if (nbits < FLD_W[p]) continue;
      v = shift_acc;
      shift_acc = '0; nbits = '0;
      if (p == EL_NUM_WINDOWS && v == 0) v = 27'd1;
      if ((p == EL_NUM_WINDOWS && v > lim_windows) || (p == EL_NUM_PCT && v > lim_pct) ||
          (p == EL_NUM_ANCHORS && v > lim_anchors)) begin
        push_field(p, win_of(p), idx_of(p), v, ST_LIMIT);
        phase = PH_ERROR;
        break;
      end
      push_field(p, win_of(p), idx_of(p), v, ST_FIELD);
      step_syntax(p, v);
      if (phase == PH_DONE) push_field(EL_COMPLETE, 2'd0, 10'd0, 27'd0, ST_DONE);
    end
    if (eom) begin
      if (phase == PH_PARSE) begin
        p = (cur_elem < NUM_ELEMS) ? cur_elem : 6'd0;
        push_field(p, win_of(p), idx_of(p), 27'd0, ST_TRUNC);
      end
      restart_parse();
    end
    if (field_q.size() > start) field_q[field_q.size() - 1].run_last = 1'b1;
  endfunction

  // Send one byte beat after a random gap, predict on acceptance
  task automatic send_byte(logic [7:0] data, logic eom);
    int gap;
    bit acc;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: data, end_of_message: eom};
    do begin
      @(negedge clk_i);
      acc = in_ready_o;
      @(posedge clk_i);
    end while (!acc);
    sent_beats++;
    predict_fields(data, eom);
  endtask

  // Drain, let the block settle, then write one register
  task automatic write_cfg(logic [1:0] idx, logic [3:0] val);
    in_valid_i <= 1'b0;
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_MAX_WINDOWS:     lim_windows = val[1:0];
      CFG_MAX_PERCENTILES: lim_pct     = val;
      CFG_MAX_ANCHORS:     lim_anchors = val;
      default: ;
    endcase
  endtask

  function automatic void put_bits(int unsigned v, int w);
    for (int i = w - 1; i >= 0; i--) bitbuf.push_back(v[i]);
  endfunction

  // Small random count, sometimes beyond the limit
  function automatic int pick_count(int lim);
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, (lim < 3) ? lim : 3);
  endfunction

  // Build a well-formed message body with random content into bitbuf
  function automatic void build_message(int nwin_code, bit tgt_grid, bit mst_grid);
    int nwin;
    int r, c, n;
    bitbuf.delete();
    put_bits($urandom, 8);
    put_bits(nwin_code, 2);
    nwin = (nwin_code == 0) ? 1 : nwin_code;
    for (int w = 1; w < nwin; w++) begin
      for (int f = 2; f <= 11; f++) put_bits($urandom, FLD_W[f]);
      put_bits($urandom, 1);
    end
    put_bits($urandom, 27);
    put_bits(tgt_grid, 1);
    if (tgt_grid) begin
      r = $urandom_range(0, 3); c = $urandom_range(0, 3);
      put_bits(r, 5); put_bits(c, 5);
      for (int i = 0; i < r * c; i++) put_bits($urandom, 4);
    end
    for (int w = 0; w < nwin; w++) begin
      for (int i = 0; i < 4; i++) put_bits($urandom, 17);
      n = pick_count(lim_pct);
      put_bits(n, 4);
      for (int i = 0; i < n; i++) begin
        put_bits($urandom, 7); put_bits($urandom, 17);
      end
      put_bits($urandom, 10);
    end
    put_bits(mst_grid, 1);
    if (mst_grid) begin
      r = $urandom_range(0, 3); c = $urandom_range(0, 3);
      put_bits(r, 5); put_bits(c, 5);
      for (int i = 0; i < r * c; i++) put_bits($urandom, 4);
    end
    for (int w = 0; w < nwin; w++) begin
      if ($urandom_range(0, 3) != 0) begin
        put_bits(1, 1);
        put_bits($urandom, 12); put_bits($urandom, 12);
        n = pick_count(lim_anchors);
        put_bits(n, 4);
        for (int i = 0; i < n; i++) put_bits($urandom, 10);
      end else begin
        put_bits(0, 1);
      end
      if ($urandom_range(0, 1) != 0) begin
        put_bits(1, 1); put_bits($urandom, 6);
      end else begin
        put_bits(0, 1);
      end
    end
  endfunction

  // Pack bitbuf into bytes, optionally cut short or padded, and send
  task automatic send_message(bit cut, int trail);
    int nbytes;
    logic [7:0] byte_v;
    nbytes = (bitbuf.size() + 7) / 8;
    if (cut) nbytes = $urandom_range(1, nbytes);
    nbytes += trail;
    for (int i = 0; i < nbytes; i++) begin
      for (int b = 0; b < 8; b++) begin
        int k;
        k = i * 8 + b;
        byte_v[7 - b] = (k < bitbuf.size()) ? bitbuf[k] : 1'($urandom_range(0, 1));
      end
      send_byte(byte_v, i == nbytes - 1);
    end
  endtask

  task automatic random_message();
    build_message($urandom_range(0, 3), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    send_message($urandom_range(0, 5) == 0, $urandom_range(0, 2));
  endtask

  // Lone bytes at the field extremes
  task automatic test_extreme_bytes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Zero window count, empty grids, short message, trailing bytes
  task automatic test_special_messages();
    build_message(0, 1'b0, 1'b0);
    send_message(1'b0, 2);
    bitbuf.delete();
    put_bits(8'h5A, 8); put_bits(0, 2); put_bits(27'h7FFFFFF, 27);
    put_bits(1, 1); put_bits(0, 5); put_bits(3, 5);
    send_message(1'b0, 0);
    build_message(2, 1'b1, 1'b1);
    send_message(1'b1, 0);
  endtask

  // Counts over limit at the register extremes
  task automatic test_limits();
    write_cfg(CFG_MAX_WINDOWS, 4'd0);
    bitbuf.delete();
    put_bits($urandom, 8); put_bits(1, 2);
    send_message(1'b0, 0);
    write_cfg(CFG_MAX_WINDOWS, 4'd1);
    write_cfg(CFG_MAX_PERCENTILES, 4'd0);
    write_cfg(CFG_MAX_ANCHORS, 4'd0);
    bitbuf.delete();
    put_bits($urandom, 8); put_bits(2, 2);
    send_message(1'b0, 0);
    build_message(1, 1'b0, 1'b0);
    send_message(1'b0, 1);
  endtask

  // Random messages across several register settings
  task automatic test_random_messages();
    int cfg_set;
    cfg_set = 0;
    do begin
      case (cfg_set % 4)
        0: begin
          write_cfg(CFG_MAX_WINDOWS, 4'd3);
          write_cfg(CFG_MAX_PERCENTILES, 4'd15);
          write_cfg(CFG_MAX_ANCHORS, 4'd15);
        end
        1: begin
          write_cfg(CFG_MAX_WINDOWS, 4'd2);
          write_cfg(CFG_MAX_PERCENTILES, 4'd2);
          write_cfg(CFG_MAX_ANCHORS, 4'd1);
        end
        2: begin
          write_cfg(CFG_MAX_WINDOWS, 4'($urandom_range(0, 3)));
          write_cfg(CFG_MAX_PERCENTILES, 4'($urandom_range(0, 15)));
          write_cfg(CFG_MAX_ANCHORS, 4'($urandom_range(0, 15)));
        end
        default: rx_stalls = 1'b0;
      endcase
      cfg_set++;
      if ($urandom_range(0, 7) == 0) begin
        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        random_message();
      end
      rx_stalls = 1'b1;
    end while (sent_beats < 100);
  endtask

  // Hold the receiver off so the block fills and stalls its input
  task automatic test_backpressure();
    rx_hold = 500;
    build_message(1, 1'b1, 1'b1);
    send_message(1'b0, 0);
  endtask

  // Receiver: random stall per result, long hold when asked
  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        stall = rx_stalls ? $urandom_range(0, 15) : 0;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expected field
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (field_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %p", out_data_o);
      end else begin
        out_t want;
        want = field_q.pop_front();
        if (out_data_o.element_id !== want.element_id ||
            out_data_o.window_index !== want.window_index ||
            out_data_o.element_index !== want.element_index ||
            out_data_o.field_value !== want.field_value ||
            out_data_o.status !== want.status ||
            out_data_o.run_last !== want.run_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  // Main sequence
  initial begin
    int settle;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    mismatches  = 0;
    sent_beats  = 0;
    rx_stalls   = 1'b1;
    rx_hold     = 0;
    lim_windows = 2'd3;
    lim_pct     = 4'd15;
    lim_anchors = 4'd15;
    restart_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_bytes();
    test_special_messages();
    test_limits();
    test_random_messages();
    test_backpressure();

    in_valid_i <= 1'b0;
    while (field_q.size() != 0) @(posedge clk_i);
    settle = 100;
    repeat (settle) @(posedge clk_i);
    if (mismatches == 0 && field_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hdmp_pkg.sv
hw/rtl/hdmp_front.sv
hw/rtl/hdmp_back.sv
hw/rtl/hdmp_dynamic_metadata_parser_top.sv
sim/hdr_dynamic_metadata_parser_top_tb.sv
